### src/scanline_rle_decoder_core_assert.svh
// Assertion macros for the decoder core's RTL.
// The clock is clk and the reset is rst in every file that uses them.
`ifndef SCANLINE_RLE_DECODER_CORE_ASSERT_SVH
`define SCANLINE_RLE_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, muted during reset
`define SRLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scanline decoder check failed");

// Next-cycle implication, muted during reset
`define SRLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scanline decoder check failed");

`endif

### src/srle_pkg.sv
`default_nettype none
package srle_pkg;

  localparam int ElemW = 16;
  localparam int RunW  = 7;
  localparam int PosW  = 16;
  localparam int EbW   = 2;
  localparam int IdxW  = 1;

  localparam logic [RunW-1:0] RunMask = 7'h7F;
  localparam int LitBit = 7;

  localparam logic [IdxW-1:0] REG_ELEM_BYTES = 1'b0;
  localparam logic [IdxW-1:0] REG_LINE_LEN   = 1'b1;

  localparam logic [EbW-1:0] EB_WIDE = 2'd2;

  // Decoder phase kept between items
  typedef enum logic [1:0] {
    PH_CTRL    = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2,
    PH_HALT    = 2'd3
  } phase_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } seq_state_t;

  // Results of the shared add-and-compare unit
  typedef struct packed {
    logic [PosW:0] sum;        // unwrapped position sum
    logic          over_len;   // unwrapped sum above line length
    logic          reach_len;  // wrapped sum at or above line length
  } alu_res_t;

endpackage
`default_nettype wire

### src/srle_in_if.sv
`default_nettype none
interface srle_in_if;
  import srle_pkg::*;

  logic             valid;
  logic             ready;
  logic [ElemW-1:0] code_elem;
  logic             line_start;

  modport source (output valid, output code_elem, output line_start, input ready);
  modport sink   (input valid, input code_elem, input line_start, output ready);
endinterface
`default_nettype wire

### src/srle_out_if.sv
`default_nettype none
interface srle_out_if;
  import srle_pkg::*;

  logic             valid;
  logic             ready;
  logic [ElemW-1:0] elem_a;
  logic [ElemW-1:0] elem_b;
  logic [1:0]       valid_count;
  logic             run_last;
  logic             line_done;
  logic             status;

  modport source (output valid, output elem_a, output elem_b, output valid_count,
                  output run_last, output line_done, output status, input ready);
  modport sink   (input valid, input elem_a, input elem_b, input valid_count,
                  input run_last, input line_done, input status, output ready);
endinterface
`default_nettype wire

### src/srle_alu.sv
`default_nettype none
module srle_alu (
  input  wire logic [srle_pkg::PosW-1:0] base,
  input  wire logic [srle_pkg::RunW-1:0] addend,
  input  wire logic [srle_pkg::PosW-1:0] limit,
  output srle_pkg::alu_res_t             res
);
  import srle_pkg::*;

  logic [PosW:0] sum;

  // Add the run to the line position and compare against the line length
  assign sum = {1'b0, base} + {{(PosW+1-RunW){1'b0}}, addend};
  assign res.sum       = sum;
  assign res.over_len  = sum > {1'b0, limit};
  assign res.reach_len = sum[PosW-1:0] >= limit;
endmodule
`default_nettype wire

### src/scanline_rle_decoder_core.sv
`default_nettype none
// Channel   Dir  Payload                                              Transfer
// code_in   in   code_elem[15:0], line_start                           valid & ready
// elem_out  out  elem_a, elem_b, valid_count, run_last, line_done,     valid & ready
//                status
// config    in   reg_index, wr_data[15:0]                             wr_en
//
// An item is taken in the idle cycle, checked in the next cycle by the shared
// add-and-compare unit, then expanded at one result per cycle while the sink
// accepts; a repeat run gives up to 64 results of up to two elements each.
// The single output register sets the emit pace; a stalled sink holds the sequencer.
// Synchronous reset rst clears the sequencer, phase, run count and line position.
// code_in.ready is high only in the idle state.
module scanline_rle_decoder_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  srle_in_if.sink                         code_in,
  srle_out_if.source                      elem_out,
  input  wire logic                       wr_en,
  input  wire logic [srle_pkg::IdxW-1:0]  reg_index,
  input  wire logic [srle_pkg::ElemW-1:0] wr_data
);
  import srle_pkg::*;
`include "scanline_rle_decoder_core_assert.svh"

  // Configuration
  logic [EbW-1:0]   elem_bytes;
  logic [PosW-1:0]  line_len;

  // Decoder state
  seq_state_t       state, state_next;
  phase_t           phase, phase_next;
  logic [RunW-1:0]  run_left, run_left_next;
  logic [PosW-1:0]  line_pos, line_pos_next;
  logic [ElemW-1:0] item_val;

  // Pending results
  logic [RunW-1:0]  emit_left, emit_left_next;
  logic             emit_done, emit_done_next;
  logic             emit_status, emit_status_next;

  // Output register
  logic             out_valid;
  logic [ElemW-1:0] out_a, out_b;
  logic [1:0]       out_cnt;
  logic             out_last, out_done, out_status;

  logic             in_xfer, out_free, emit_fire;
  logic [RunW-1:0]  addend, ctrl_run;
  logic [1:0]       cnt;
  logic             last;
  alu_res_t         alu;

  assign in_xfer   = code_in.valid && code_in.ready;
  assign out_free  = !out_valid || elem_out.ready;
  assign emit_fire = (state == ST_EMIT) && out_free;
  assign ctrl_run  = item_val[RunW-1:0] & RunMask;

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_bytes <= EbW'(1);
      line_len   <= PosW'(1);
    end else if (wr_en) begin
      unique case (reg_index)
        REG_ELEM_BYTES: elem_bytes <= wr_data[EbW-1:0];
        REG_LINE_LEN:   line_len   <= wr_data[PosW-1:0];
        default:        ;
      endcase
    end
  end

  // Select the operand for the shared unit
  always_comb begin
    unique case (phase)
      PH_CTRL:   addend = ctrl_run;
      PH_REPEAT: addend = run_left;
      default:   addend = RunW'(1);
    endcase
  end

  srle_alu u_alu (
    .base   (line_pos),
    .addend (addend),
    .limit  (line_len),
    .res    (alu)
  );

  // Size the next result
  assign cnt  = (emit_left >= RunW'(2)) ? 2'd2 : emit_left[1:0];
  assign last = emit_left <= RunW'(2);

  // Sequence one item: check, then emit any results
  always_comb begin
    state_next       = state;
    phase_next       = phase;
    run_left_next    = run_left;
    line_pos_next    = line_pos;
    emit_left_next   = emit_left;
    emit_done_next   = emit_done;
    emit_status_next = emit_status;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_CHECK;
          if (code_in.line_start) begin
            phase_next    = PH_CTRL;
            run_left_next = '0;
            line_pos_next = '0;
          end
        end
      end
      ST_CHECK: begin
        state_next       = ST_IDLE;
        emit_status_next = 1'b0;
        emit_done_next   = 1'b0;
        emit_left_next   = '0;
        unique case (phase)
          PH_CTRL: begin
            if (alu.over_len) begin
              emit_status_next = 1'b1;
              phase_next       = PH_HALT;
              state_next       = ST_EMIT;
            end else if (ctrl_run == '0) begin
              emit_done_next = 1'b1;
              phase_next     = PH_HALT;
              state_next     = ST_EMIT;
            end else begin
              run_left_next = ctrl_run;
              phase_next    = item_val[LitBit] ? PH_LITERAL : PH_REPEAT;
            end
          end
          PH_REPEAT: begin
            line_pos_next  = alu.sum[PosW-1:0];
            emit_done_next = alu.reach_len;
            emit_left_next = run_left;
            run_left_next  = '0;
            phase_next     = alu.reach_len ? PH_HALT : PH_CTRL;
            state_next     = (run_left == '0) ? ST_IDLE : ST_EMIT;
          end
          PH_LITERAL: begin
            line_pos_next  = alu.sum[PosW-1:0];
            emit_done_next = alu.reach_len;
            emit_left_next = RunW'(1);
            state_next     = ST_EMIT;
            if (alu.reach_len) begin
              run_left_next = '0;
              phase_next    = PH_HALT;
            end else begin
              run_left_next = run_left - RunW'(1);
              if (run_left == RunW'(1)) begin
                phase_next = PH_CTRL;
              end
            end
          end
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (out_free) begin
          emit_left_next = emit_left - {{(RunW-2){1'b0}}, cnt};
          if (last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_CTRL;
      run_left <= '0;
      line_pos <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      run_left <= run_left_next;
      line_pos <= line_pos_next;
    end
  end

  // Hold the item value and pending result fields
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_val <= (elem_bytes == EB_WIDE) ? code_in.code_elem
                                          : {8'h00, code_in.code_elem[7:0]};
    end
    emit_left   <= emit_left_next;
    emit_done   <= emit_done_next;
    emit_status <= emit_status_next;
  end

  // Load the output register, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (elem_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_a      <= (cnt != 2'd0) ? item_val : '0;
      out_b      <= (cnt == 2'd2) ? item_val : '0;
      out_cnt    <= cnt;
      out_last   <= last;
      out_done   <= last && emit_done;
      out_status <= emit_status;
    end
  end

  assign code_in.ready        = (state == ST_IDLE);
  assign elem_out.valid       = out_valid;
  assign elem_out.elem_a      = out_a;
  assign elem_out.elem_b      = out_b;
  assign elem_out.valid_count = out_cnt;
  assign elem_out.run_last    = out_last;
  assign elem_out.line_done   = out_done;
  assign elem_out.status      = out_status;

  `SRLE_ASSERT_NEXT(a_take_then_check, in_xfer, state == ST_CHECK)
  `SRLE_ASSERT_NOW(a_empty_is_last, out_valid && (out_cnt == 2'd0), out_last)
  `SRLE_ASSERT_NOW(a_done_xor_err, out_valid, !(out_done && out_status))
  `SRLE_ASSERT_NOW(a_idle_run_clear, (phase == PH_CTRL) || (phase == PH_HALT),
                   run_left == '0)
endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import srle_pkg::*;

  // One decoded result as it leaves the block
  typedef struct packed {
    logic [ElemW-1:0] elem_a;
    logic [ElemW-1:0] elem_b;
    logic [1:0]       valid_count;
    logic             run_last;
    logic             line_done;
    logic             status;
  } decoded_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             wr_en = 1'b0;
  logic [IdxW-1:0]  reg_index = '0;
  logic [ElemW-1:0] wr_data = '0;

  srle_in_if  code_in ();
  srle_out_if elem_out ();

  scanline_rle_decoder_core u_top (
    .clk       (clk),
    .rst       (rst),
    .code_in   (code_in),
    .elem_out  (elem_out),
    .wr_en     (wr_en),
    .reg_index (reg_index),
    .wr_data   (wr_data)
  );

  // Decoder mirror: configuration and line state
  logic [EbW-1:0]   elem_bytes_q;
  logic [PosW-1:0]  line_len_q;
  phase_t           dec_phase;
  logic [RunW-1:0]  run_left_q;
  logic [PosW-1:0]  line_pos_q;
  decoded_t         decoded_fifo[$];

  int err_cnt = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 69;
  int hold_req = 0;
  int hold_cnt = 0;
  logic hold_taken = 1'b0;

  always #5 clk = ~clk;

  function automatic void push_decoded(input logic [ElemW-1:0] a, input logic [ElemW-1:0] b,
                                       input logic [1:0] cnt, input logic last,
                                       input logic done, input logic st);
    decoded_t r;
    r.elem_a      = a;
    r.elem_b      = b;
    r.valid_count = cnt;
    r.run_last    = last;
    r.line_done   = done;
    r.status      = st;
    decoded_fifo.push_back(r);
  endfunction

  // Advance the mirror by one accepted code element and queue its results
  function automatic void decode_code_elem(input logic [ElemW-1:0] code, input logic ls);
    logic [ElemW-1:0] v;
    int               run;
    int               left;
    int               cnt;
    logic             fill;
    v = code;
    if (elem_bytes_q != EB_WIDE) v[ElemW-1:8] = '0;
    if (ls) begin
      dec_phase  = PH_CTRL;
      run_left_q = '0;
      line_pos_q = '0;
    end
    case (dec_phase)
      PH_CTRL: begin
        run = v[RunW-1:0];
        // Run too long is checked ahead of the end marker
        if (line_pos_q + run > line_len_q) begin
          push_decoded('0, '0, 2'd0, 1'b1, 1'b0, 1'b1);
          dec_phase = PH_HALT;
        end else if (run == 0) begin
          push_decoded('0, '0, 2'd0, 1'b1, 1'b1, 1'b0);
          dec_phase = PH_HALT;
        end else begin
          run_left_q = v[RunW-1:0];
          dec_phase  = v[LitBit] ? PH_LITERAL : PH_REPEAT;
        end
      end
      PH_REPEAT: begin
        left       = run_left_q;
        line_pos_q = line_pos_q + left[PosW-1:0];
        fill       = (line_pos_q >= line_len_q);
        while (left > 0) begin
          cnt = (left >= 2) ? 2 : 1;
          push_decoded(v, (cnt == 2) ? v : '0, cnt[1:0], left == cnt,
                       (left == cnt) && fill, 1'b0);
          left -= cnt;
        end
        run_left_q = '0;
        dec_phase  = fill ? PH_HALT : PH_CTRL;
      end
      PH_LITERAL: begin
        line_pos_q = line_pos_q + 1'b1;
        run_left_q = run_left_q - 1'b1;
        fill       = (line_pos_q >= line_len_q);
        push_decoded(v, '0, 2'd1, 1'b1, fill, 1'b0);
        if (fill) begin
          run_left_q = '0;
          dec_phase  = PH_HALT;
        end else if (run_left_q == 0) begin
          dec_phase = PH_CTRL;
        end
      end
      default: ;
    endcase
  endfunction

  // Drop valid, wait for every queued result, then let the block settle
  task automatic wait_idle();
    code_in.valid <= 1'b0;
    while (decoded_fifo.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic configure(input logic [EbW-1:0] eb, input logic [PosW-1:0] len);
    wait_idle();
    wr_en     <= 1'b1;
    reg_index <= REG_ELEM_BYTES;
    wr_data   <= ElemW'(eb);
    @(negedge clk);
    elem_bytes_q = eb;
    reg_index <= REG_LINE_LEN;
    wr_data   <= len;
    @(negedge clk);
    line_len_q = len;
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one code element and hold it until the transfer
  task automatic send_code(input logic [ElemW-1:0] code, input logic ls);
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      code_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    code_in.valid      <= 1'b1;
    code_in.code_elem  <= code;
    code_in.line_start <= ls;
    @(posedge clk);
    while (!code_in.ready) @(posedge clk);
    decode_code_elem(code, ls);
    @(negedge clk);
  endtask

  // Receiver: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req != 0 && !hold_taken) begin
      hold_cnt   = hold_req;
      hold_taken = 1'b1;
    end
    if (hold_cnt != 0) begin
      hold_cnt--;
      elem_out.ready <= 1'b0;
    end else begin
      elem_out.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      if (err_cnt < 30)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      err_cnt++;
    end
  endfunction

  // Compare each result transfer with the oldest queued result
  always @(posedge clk) begin
    decoded_t got;
    decoded_t want;
    if (!rst && elem_out.valid && elem_out.ready) begin
      got.elem_a      = elem_out.elem_a;
      got.elem_b      = elem_out.elem_b;
      got.valid_count = elem_out.valid_count;
      got.run_last    = elem_out.run_last;
      got.line_done   = elem_out.line_done;
      got.status      = elem_out.status;
      if (decoded_fifo.size() == 0) begin
        if (err_cnt < 30)
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
        err_cnt++;
      end else begin
        want = decoded_fifo.pop_front();
        check_field("elem_a", want.elem_a, got.elem_a);
        check_field("elem_b", want.elem_b, got.elem_b);
        check_field("valid_count", want.valid_count, got.valid_count);
        check_field("run_last", want.run_last, got.run_last);
        check_field("line_done", want.line_done, got.line_done);
        check_field("status", want.status, got.status);
      end
    end
  end

  // Reset values: 8-bit elements, one-element line; halted input is ignored
  task automatic test_defaults();
    send_code(16'h0081, 1'b1);
    send_code(16'h1234, 1'b0);
    send_code(16'h00FF, 1'b0);
  endtask

  // Longest repeat run, literals with masked high bits, end marker
  task automatic test_narrow_runs();
    configure(2'd1, 16'd300);
    send_code(16'hFF7F, 1'b1);
    send_code(16'hABCD, 1'b0);
    send_code(16'h0082, 1'b0);
    send_code(16'hFF00, 1'b0);
    send_code(16'h00FF, 1'b0);
    send_code(16'h0100, 1'b0);
  endtask

  // Odd width code, run past the line end, exact fill, restart mid-run
  task automatic test_overflow_fill();
    configure(2'd3, 16'd10);
    send_code(16'h000B, 1'b1);
    send_code(16'h000A, 1'b1);
    send_code(16'hFFEE, 1'b0);
    send_code(16'h0085, 1'b1);
    send_code(16'h0011, 1'b0);
    send_code(16'h0082, 1'b1);
    send_code(16'h0022, 1'b0);
    send_code(16'h0033, 1'b0);
  endtask

  // Shrink the line length in the middle of a line
  task automatic test_len_change();
    configure(2'd0, 16'd20);
    send_code(16'h0005, 1'b1);
    send_code(16'h0077, 1'b0);
    configure(2'd0, 16'd3);
    send_code(16'h0000, 1'b0);
    configure(2'd0, 16'd20);
    send_code(16'h008A, 1'b1);
    send_code(16'h0041, 1'b0);
    send_code(16'h0042, 1'b0);
    configure(2'd0, 16'd2);
    send_code(16'h0043, 1'b0);
  endtask

  // 16-bit elements, longest line
  task automatic test_wide();
    configure(EB_WIDE, 16'hFFFF);
    send_code(16'h7F82, 1'b1);
    send_code(16'hFFFF, 1'b0);
    send_code(16'h0000, 1'b0);
    send_code(16'h8003, 1'b0);
    send_code(16'hA5C3, 1'b0);
    send_code(16'hFF00, 1'b0);
  endtask

  // Hold the receiver off while long runs keep arriving
  task automatic test_backpressure();
    int saved_pct;
    configure(2'd1, 16'd400);
    saved_pct     = send_idle_pct;
    send_idle_pct = 0;
    hold_req      = 300;
    send_code(16'h007F, 1'b1);
    send_code(16'h0099, 1'b0);
    send_code(16'h007F, 1'b0);
    send_code(16'h0066, 1'b0);
    send_code(16'h0000, 1'b0);
    send_idle_pct = saved_pct;
    wait_idle();
  endtask

  // One scanline: mostly well-formed runs, with end markers, overruns and restarts
  task automatic send_random_line(inout int sent);
    int               steps;
    int               room;
    int               cap;
    int               run;
    int               pick;
    logic [ElemW-1:0] code;
    logic             ls;
    steps = 0;
    do begin
      code = ElemW'($urandom);
      if (steps == 0 || dec_phase == PH_CTRL) begin
        room = (steps == 0) ? line_len_q : line_len_q - line_pos_q;
        cap  = (room < 127) ? room : 127;
        pick = $urandom_range(99);
        if (pick < 6)
          run = 0;
        else if (pick < 12 && room < 127)
          run = $urandom_range(room + 1, 127);
        else if ($urandom_range(9) == 0)
          run = $urandom_range(1, cap);
        else
          run = $urandom_range(1, (cap < 6) ? cap : 6);
        code[RunW-1:0] = run[RunW-1:0];
        ls = (steps == 0) || ($urandom_range(29) == 0);
      end else begin
        ls = ($urandom_range(39) == 0);
      end
      send_code(code, ls);
      steps++;
      sent++;
    end while (dec_phase != PH_HALT && steps < 16);
    // Trailing noise on a halted line
    if (dec_phase == PH_HALT && $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) send_code(ElemW'($urandom), 1'b0);
    end
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    int               sent;
    int               pick;
    logic [PosW-1:0]  len;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < count) begin
      if (sent == 0 || $urandom_range(3) == 0) begin
        pick = $urandom_range(99);
        if (pick < 5)
          len = 16'd1;
        else if (pick < 15)
          len = 16'hFFFF;
        else if (pick < 30)
          len = PosW'($urandom_range(41, 400));
        else
          len = PosW'($urandom_range(1, 40));
        configure(EbW'($urandom_range(0, 3)), len);
      end
      send_random_line(sent);
    end
    wait_idle();
  endtask

  initial begin
    code_in.valid      = 1'b0;
    code_in.code_elem  = '0;
    code_in.line_start = 1'b0;
    elem_bytes_q = 2'd1;
    line_len_q   = 16'd1;
    dec_phase    = PH_CTRL;
    run_left_q   = '0;
    line_pos_q   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_defaults();
    test_narrow_runs();
    test_overflow_fill();
    test_len_change();
    test_wide();
    test_backpressure();
    test_random(120, 22, 69);
    test_random(120, 69, 22);
    test_random(120, 0, 0);

    wait_idle();
    repeat (16) @(negedge clk);
    if (err_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
